@@ rtl/unique_set_statistics_top_defines.svh @@
// ----------------------------------------------------------------------------
// Unique set statistics: assertion macros
// Shared helpers for the concurrent checks in the set statistics block.
// ----------------------------------------------------------------------------
`ifndef UNIQUE_SET_STATISTICS_TOP_DEFINES_SVH
`define UNIQUE_SET_STATISTICS_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define USS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define USS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/uss_pkg.sv @@
// ----------------------------------------------------------------------------
// Unique set statistics package
// Field widths, action codes and status codes shared by the block's modules.
// ----------------------------------------------------------------------------
`default_nettype none

package uss_pkg;

    // Field widths that do not depend on the capacity.
    localparam int VALUE_W  = 32;
    localparam int MEAN_W   = 40;
    localparam int FRAC_W   = 8;
    localparam int ACTION_W = 2;
    localparam int STATUS_W = 3;

    // Action codes carried on the input tuser.
    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd2;

    // Status codes returned with every result.
    localparam logic [STATUS_W-1:0] STAT_ADDED   = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_DUP     = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL    = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_CLEARED = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_EMPTY   = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_QUERY   = 3'd5;
    localparam logic [STATUS_W-1:0] STAT_NODATA  = 3'd6;

endpackage

`default_nettype wire

@@ rtl/unique_set_statistics_top.sv @@
// ----------------------------------------------------------------------------
// Unique set statistics
// Set of distinct signed 32-bit values with count, minimum, maximum and mean.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one command per transfer: tuser holds the action
//   (insert, clear, query; the unused code acts as a query) and tdata the
//   value to insert. Each command yields exactly one result transfer on the
//   master stream: tuser holds the status and the statistics-valid flag,
//   tdata the entry count, minimum, maximum and the mean times 256.
//   One command is processed at a time. An insert scans the stored entries
//   through the registered-read entry memory, one entry per cycle, until it
//   finds a match or reaches the last entry. The mean then comes from a
//   bit-serial divider of 32+log2(CAPACITY)+8 steps (46 at the default
//   capacity), which runs only when the set is non-empty afterwards. The
//   block is ready for the next command as soon as the result is registered.
//   A finished result waits in the output register while the next command
//   is already accepted; the block holds the following result back until
//   the receiver has taken the previous one.
//   Reset empties the set at once (no clearing pass); entry contents are
//   never searched beyond the current count.
// ----------------------------------------------------------------------------
`default_nettype none

`include "unique_set_statistics_top_defines.svh"

module unique_set_statistics_top #(
    parameter int CAPACITY = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Command stream.
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    // tdata fields, lowest bit up: value[31:0].
    input  wire logic [31:0]           i_s_tdata,
    // tuser fields, lowest bit up: action[1:0].
    input  wire logic [1:0]            i_s_tuser,
    // Result stream.
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    // tdata fields, lowest bit up: entry_count, minimum[31:0], maximum[31:0],
    // mean_fixed[39:0], zero padding to whole bytes.
    output logic [(($clog2(CAPACITY+1) + 104 + 7) / 8) * 8 - 1:0] o_m_tdata,
    // tuser fields, lowest bit up: status[2:0], stats_valid.
    output logic [3:0]                 o_m_tuser
);

    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int ADDR_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int SUM_W   = uss_pkg::VALUE_W + ((CAPACITY > 1) ? $clog2(CAPACITY) : 0);
    localparam int NUM_W   = SUM_W + uss_pkg::FRAC_W;
    localparam int FIELD_W = CNT_W + 2 * uss_pkg::VALUE_W + uss_pkg::MEAN_W;
    localparam int TDATA_W = ((FIELD_W + 7) / 8) * 8;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SCAN   = 6'b000010,
        S_APPLY  = 6'b000100,
        S_DSTART = 6'b001000,
        S_DWAIT  = 6'b010000,
        S_DONE   = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // Set state.
    logic        [CNT_W-1:0]            r_count, n_count;
    logic signed [SUM_W-1:0]            r_sum, n_sum;
    logic signed [uss_pkg::VALUE_W-1:0] r_min, n_min;
    logic signed [uss_pkg::VALUE_W-1:0] r_max, n_max;

    // Command in progress.
    logic        [uss_pkg::ACTION_W-1:0] r_action, n_action;
    logic signed [uss_pkg::VALUE_W-1:0]  r_value, n_value;
    logic        [ADDR_W-1:0]            r_idx, n_idx;
    logic                                r_found, n_found;
    logic        [uss_pkg::STATUS_W-1:0] r_status, n_status;

    // Output register.
    logic               r_out_valid, n_out_valid;
    logic [TDATA_W-1:0] r_out_tdata, n_out_tdata;
    logic [3:0]         r_out_tuser, n_out_tuser;

    // Memory and divider connections.
    logic                               w_wr_en;
    logic                               w_rd_en;
    logic [ADDR_W-1:0]                  w_rd_addr;
    logic [uss_pkg::VALUE_W-1:0]        w_rd_data;
    logic                               w_div_start;
    logic                               w_div_done;
    logic signed [uss_pkg::MEAN_W-1:0]  w_div_quot;
    logic signed [NUM_W-1:0]            w_div_num;

    logic                               w_accept;
    logic                               w_out_free;
    logic                               w_scan_last;
    logic                               w_stats;
    logic [uss_pkg::MEAN_W-1:0]         w_mean;

    assign w_accept    = i_s_tvalid && o_s_tready;
    assign w_out_free  = !r_out_valid || i_m_tready;
    assign w_scan_last = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);
    assign w_stats     = (r_count != '0);
    assign w_mean      = w_stats ? w_div_quot : '0;
    assign w_div_num   = {r_sum, uss_pkg::FRAC_W'(0)};
    assign w_div_start = (r_state == S_DSTART);

    // Entry write happens only when an insert is applied and appends.
    assign w_wr_en = (r_state == S_APPLY) && (r_action == uss_pkg::ACT_INSERT)
                     && !r_found && (r_count < CNT_W'(CAPACITY));

    // Entry reads: the first entry on acceptance of any command, the next ones
    // during the scan.
    always_comb begin
        w_rd_en   = 1'b0;
        w_rd_addr = '0;
        if ((r_state == S_IDLE) && w_accept) begin
            w_rd_en = 1'b1;
        end else if ((r_state == S_SCAN) && (w_rd_data != r_value) && !w_scan_last) begin
            w_rd_en   = 1'b1;
            w_rd_addr = r_idx + ADDR_W'(1);
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_tdata;
    assign o_m_tuser  = r_out_tuser;

    // Sequencer: search, state update, division and result hand-off.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_sum       = r_sum;
        n_min       = r_min;
        n_max       = r_max;
        n_action    = r_action;
        n_value     = r_value;
        n_idx       = r_idx;
        n_found     = r_found;
        n_status    = r_status;
        n_out_valid = r_out_valid;
        n_out_tdata = r_out_tdata;
        n_out_tuser = r_out_tuser;

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_action = i_s_tuser;
                    n_value  = i_s_tdata;
                    n_idx    = '0;
                    n_found  = 1'b0;
                    if ((i_s_tuser == uss_pkg::ACT_INSERT) && (r_count != '0)) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_APPLY;
                    end
                end
            end
            S_SCAN: begin
                if (w_rd_data == r_value) begin
                    n_found = 1'b1;
                    n_state = S_APPLY;
                end else if (w_scan_last) begin
                    n_state = S_APPLY;
                end else begin
                    n_idx = r_idx + ADDR_W'(1);
                end
            end
            S_APPLY: begin
                case (r_action)
                    uss_pkg::ACT_INSERT: begin
                        if (r_found) begin
                            n_status = uss_pkg::STAT_DUP;
                        end else if (r_count >= CNT_W'(CAPACITY)) begin
                            n_status = uss_pkg::STAT_FULL;
                        end else begin
                            n_status = uss_pkg::STAT_ADDED;
                            n_count  = r_count + CNT_W'(1);
                            n_sum    = r_sum + SUM_W'(r_value);
                            if ((r_count == '0) || (r_value < r_min)) begin
                                n_min = r_value;
                            end
                            if ((r_count == '0) || (r_value > r_max)) begin
                                n_max = r_value;
                            end
                        end
                    end
                    uss_pkg::ACT_CLEAR: begin
                        if (r_count == '0) begin
                            n_status = uss_pkg::STAT_EMPTY;
                        end else begin
                            n_status = uss_pkg::STAT_CLEARED;
                            n_count  = '0;
                            n_sum    = '0;
                            n_min    = '0;
                            n_max    = '0;
                        end
                    end
                    default: begin
                        n_status = (r_count != '0) ? uss_pkg::STAT_QUERY
                                                   : uss_pkg::STAT_NODATA;
                    end
                endcase
                n_state = (n_count != '0) ? S_DSTART : S_DONE;
            end
            S_DSTART: begin
                n_state = S_DWAIT;
            end
            S_DWAIT: begin
                if (w_div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_tdata = TDATA_W'({w_mean,
                                            w_stats ? r_max : uss_pkg::VALUE_W'(0),
                                            w_stats ? r_min : uss_pkg::VALUE_W'(0),
                                            r_count});
                    n_out_tuser = {w_stats, r_status};
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control and set-state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_sum       <= '0;
            r_min       <= '0;
            r_max       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_sum       <= n_sum;
            r_min       <= n_min;
            r_max       <= n_max;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_action    <= n_action;
        r_value     <= n_value;
        r_idx       <= n_idx;
        r_found     <= n_found;
        r_status    <= n_status;
        r_out_tdata <= n_out_tdata;
        r_out_tuser <= n_out_tuser;
    end

    uss_entry_ram #(
        .DEPTH  (CAPACITY),
        .ADDR_W (ADDR_W)
    ) u_entry_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_count[ADDR_W-1:0]),
        .i_wr_data (r_value),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    uss_mean_div #(
        .NUM_W (NUM_W),
        .DEN_W (CNT_W)
    ) u_mean_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (r_count),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    // Checks on the sequencer.
    `USS_ASSERT_NOW(a_wr_below_capacity, i_clk, i_rst_n, w_wr_en,
        r_count < CNT_W'(CAPACITY), "entry write with the set full")
    `USS_ASSERT_NEXT(a_wr_counts_up, i_clk, i_rst_n, w_wr_en,
        r_count == $past(r_count) + CNT_W'(1), "entry write did not grow the count")
    `USS_ASSERT_NOW(a_div_done_in_wait, i_clk, i_rst_n, w_div_done,
        r_state == S_DWAIT, "divider finished outside its wait state")
    `USS_ASSERT_NOW(a_empty_status, i_clk, i_rst_n,
        (r_state == S_DONE) && (r_count == '0),
        (r_status == uss_pkg::STAT_CLEARED) || (r_status == uss_pkg::STAT_EMPTY) ||
        (r_status == uss_pkg::STAT_NODATA), "empty set with a non-empty status")

endmodule

`default_nettype wire

@@ rtl/uss_entry_ram.sv @@
// ----------------------------------------------------------------------------
// Unique set statistics entry memory
// Single-port-write, single-port-read storage for the set entries, with a
// registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module uss_entry_ram #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_wr_en,
    input  wire logic [ADDR_W-1:0]           i_wr_addr,
    input  wire logic [uss_pkg::VALUE_W-1:0] i_wr_data,
    input  wire logic                        i_rd_en,
    input  wire logic [ADDR_W-1:0]           i_rd_addr,
    output logic      [uss_pkg::VALUE_W-1:0] o_rd_data
);

    logic [uss_pkg::VALUE_W-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/uss_mean_div.sv @@
// ----------------------------------------------------------------------------
// Unique set statistics mean divider
// Restoring division, one quotient bit per cycle, of a signed numerator by an
// unsigned entry count. The quotient is truncated toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module uss_mean_div #(
    parameter int NUM_W = 46,
    parameter int DEN_W = 7
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_start,
    input  wire logic signed [NUM_W-1:0]          i_num,
    input  wire logic        [DEN_W-1:0]          i_den,
    output logic                                  o_done,
    output logic signed [uss_pkg::MEAN_W-1:0]     o_quot
);

    localparam int STEP_W = $clog2(NUM_W + 1);

    logic              r_busy;
    logic [STEP_W-1:0] r_steps;
    logic              r_neg;
    logic [NUM_W-1:0]  r_quo;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;

    logic [NUM_W-1:0]  w_num_mag;
    logic [DEN_W:0]    w_rem_sh;
    logic              w_fits;
    logic [DEN_W:0]    w_rem_sub;
    logic [NUM_W-1:0]  w_quo_next;
    logic [NUM_W-1:0]  w_quo_signed;

    // Magnitude of the numerator; the sign is applied at the end.
    assign w_num_mag = i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    assign w_rem_sh     = {r_rem, r_quo[NUM_W-1]};
    assign w_fits       = (w_rem_sh >= {1'b0, r_den});
    assign w_rem_sub    = w_rem_sh - {1'b0, r_den};
    assign w_quo_next   = {r_quo[NUM_W-2:0], w_fits};
    assign w_quo_signed = r_neg ? (~w_quo_next + NUM_W'(1)) : w_quo_next;

    // Control: busy flag, step counter and done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_steps <= '0;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_steps <= STEP_W'(NUM_W);
            end else if (r_busy) begin
                r_steps <= r_steps - STEP_W'(1);
                if (r_steps == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: dividend/quotient shift register and partial remainder.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[NUM_W-1];
            r_quo <= w_num_mag;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= w_quo_next;
            r_rem <= w_fits ? w_rem_sub[DEN_W-1:0] : w_rem_sh[DEN_W-1:0];
            if (r_steps == STEP_W'(1)) begin
                o_quot <= w_quo_signed[uss_pkg::MEAN_W-1:0];
            end
        end
    end

endmodule

`default_nettype wire

@@ sim/uss_stats_checker.sv @@
// ----------------------------------------------------------------------------
// Unique set statistics: result checker
// Watches the command and result streams and keeps its own copy of the set.
// For each accepted command it computes the expected status, count, minimum,
// maximum and mean. It compares each result transfer with the oldest
// expectation and counts the failures for the testbench top.
// ----------------------------------------------------------------------------
`default_nettype none

module uss_stats_checker #(
    parameter int CAPACITY = 64,
    parameter int CNT_W    = $clog2(CAPACITY + 1),
    parameter int M_DATA_W = ((CNT_W + 104 + 7) / 8) * 8
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // Command stream, as seen on the block's slave side.
    input  wire logic                i_s_tvalid,
    input  wire logic                i_s_tready,
    // tdata fields, lowest bit up: value[31:0].
    input  wire logic [31:0]         i_s_tdata,
    // tuser fields, lowest bit up: action[1:0].
    input  wire logic [1:0]          i_s_tuser,
    // Result stream, as seen on the block's master side.
    input  wire logic                i_m_tvalid,
    input  wire logic                i_m_tready,
    // tdata fields, lowest bit up: entry_count, minimum, maximum, mean_fixed.
    input  wire logic [M_DATA_W-1:0] i_m_tdata,
    // tuser fields, lowest bit up: status[2:0], stats_valid.
    input  wire logic [3:0]          i_m_tuser,
    output int                       o_fail_count,
    output int                       o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // One result transfer, split into its fields.
    typedef struct {
        logic [uss_pkg::STATUS_W-1:0]      status;
        logic [CNT_W-1:0]                  entry_count;
        logic                              stats_valid;
        logic signed [31:0]                minimum;
        logic signed [31:0]                maximum;
        logic signed [uss_pkg::MEAN_W-1:0] mean_fixed;
    } t_set_stats;

    // Shadow copy of the set and its running statistics.
    logic [31:0]        stored_vals [CAPACITY];
    int                 stored_count;
    longint             value_sum;
    logic signed [31:0] low_val;
    logic signed [31:0] high_val;

    t_set_stats expected_stats [$];
    int         result_idx;
    int         failure_reports;

    // Applies one command to the shadow set and returns the result it causes.
    task automatic predict_set_op(input logic [1:0] action, input logic signed [31:0] value,
                                  output t_set_stats res);
        logic   present;
        longint mean_wide;
        int     i;
        present = 1'b0;
        for (i = 0; i < stored_count; i++) begin
            if (stored_vals[i] == value) begin
                present = 1'b1;
            end
        end
        if (action == uss_pkg::ACT_INSERT) begin
            // The search comes first, so a duplicate is reported even when full.
            if (present) begin
                res.status = uss_pkg::STAT_DUP;
            end else if (stored_count >= CAPACITY) begin
                res.status = uss_pkg::STAT_FULL;
            end else begin
                stored_vals[stored_count] = value;
                if (stored_count == 0) begin
                    low_val  = value;
                    high_val = value;
                end else begin
                    if (value < low_val) begin
                        low_val = value;
                    end
                    if (value > high_val) begin
                        high_val = value;
                    end
                end
                value_sum = value_sum + longint'(value);
                stored_count++;
                res.status = uss_pkg::STAT_ADDED;
            end
        end else if (action == uss_pkg::ACT_CLEAR) begin
            if (stored_count == 0) begin
                res.status = uss_pkg::STAT_EMPTY;
            end else begin
                stored_count = 0;
                value_sum    = 0;
                low_val      = '0;
                high_val     = '0;
                res.status   = uss_pkg::STAT_CLEARED;
            end
        end else begin
            // Query, and the unused action code behaves the same way.
            res.status = (stored_count != 0) ? uss_pkg::STAT_QUERY : uss_pkg::STAT_NODATA;
        end

        // Mean times 256; SystemVerilog division truncates toward zero.
        mean_wide = 0;
        if (stored_count != 0) begin
            mean_wide = (value_sum * 256) / longint'(stored_count);
        end
        res.entry_count = stored_count[CNT_W-1:0];
        res.stats_valid = (stored_count != 0);
        res.minimum     = (stored_count != 0) ? low_val : '0;
        res.maximum     = (stored_count != 0) ? high_val : '0;
        res.mean_fixed  = mean_wide[uss_pkg::MEAN_W-1:0];
    endtask

    // Counts a failure; only the first ten are described.
    task automatic report_failure(input string what);
        o_fail_count++;
        if (failure_reports < 10) begin
            $display("[%0t] ERROR: %s", $realtime, what);
        end
        failure_reports++;
    endtask

    // Results are handled before commands: a result taken at the same edge
    // as a command always belongs to an earlier command.
    always @(posedge i_clk) begin
        t_set_stats exp_res;
        t_set_stats got_res;
        if (!i_rst_n) begin
            stored_count    = 0;
            value_sum       = 0;
            low_val         = '0;
            high_val        = '0;
            result_idx      = 0;
            failure_reports = 0;
            o_fail_count    = 0;
            expected_stats.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got_res.status      = i_m_tuser[uss_pkg::STATUS_W-1:0];
                got_res.stats_valid = i_m_tuser[uss_pkg::STATUS_W];
                got_res.entry_count = i_m_tdata[CNT_W-1:0];
                got_res.minimum     = i_m_tdata[CNT_W +: 32];
                got_res.maximum     = i_m_tdata[CNT_W + 32 +: 32];
                got_res.mean_fixed  = i_m_tdata[CNT_W + 64 +: uss_pkg::MEAN_W];
                if (expected_stats.size() == 0) begin
                    report_failure($sformatf("result %0d arrived with no command waiting",
                                             result_idx));
                end else begin
                    exp_res = expected_stats.pop_front();
                    if (got_res.status !== exp_res.status
                            || got_res.entry_count !== exp_res.entry_count
                            || got_res.stats_valid !== exp_res.stats_valid
                            || got_res.minimum !== exp_res.minimum
                            || got_res.maximum !== exp_res.maximum
                            || got_res.mean_fixed !== exp_res.mean_fixed) begin
                        report_failure($sformatf({"result %0d: expected status %0d count %0d ",
                            "valid %0b min %0d max %0d mean %0d, got status %0d count %0d ",
                            "valid %0b min %0d max %0d mean %0d"}, result_idx,
                            exp_res.status, exp_res.entry_count, exp_res.stats_valid,
                            exp_res.minimum, exp_res.maximum, exp_res.mean_fixed,
                            got_res.status, got_res.entry_count, got_res.stats_valid,
                            got_res.minimum, got_res.maximum, got_res.mean_fixed));
                    end
                end
                result_idx++;
            end
            if (i_s_tvalid && i_s_tready) begin
                predict_set_op(i_s_tuser, i_s_tdata, exp_res);
                expected_stats.insert(expected_stats.size(), exp_res);
            end
        end
        o_pending = expected_stats.size();
    end

endmodule

`default_nettype wire

@@ sim/tb_unique_set_statistics_top.sv @@
// ----------------------------------------------------------------------------
// Unique set statistics: testbench top
// Drives insert, clear and query commands into the block and takes its
// results. A short directed run covers the empty set, the value extremes and
// the unused action code. Random bursts then fill the set past its capacity
// with many repeated values, each burst ending in a clear. Both sides stall
// at random, and the checker beside the block judges every result.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_unique_set_statistics_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SET_CAP  = 64;
    localparam int CNT_W    = $clog2(SET_CAP + 1);
    localparam int M_DATA_W = ((CNT_W + 104 + 7) / 8) * 8;

    // The fourth action code is not used by the block and acts as a query.
    localparam logic [uss_pkg::ACTION_W-1:0] ACT_SPARE = 2'd3;

    localparam int RANDOM_ITEMS = 1030;
    localparam int HOLD_CYCLES  = 400;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_s_tvalid;
    logic                o_s_tready;
    logic [31:0]         i_s_tdata;
    logic [1:0]          i_s_tuser;
    logic                o_m_tvalid;
    logic                i_m_tready;
    logic [M_DATA_W-1:0] o_m_tdata;
    logic [3:0]          o_m_tuser;

    int fail_count;
    int pending;

    // Idle rates in percent for each side, and a request for a long stall.
    int send_idle_pct;
    int recv_idle_pct;
    bit hold_off_req;

    // Values inserted since the last clear, reused to provoke duplicates.
    logic [31:0] inserted_vals [$];

    unique_set_statistics_top #(
        .CAPACITY(SET_CAP)
    ) DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .i_s_tuser (i_s_tuser),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata),
        .o_m_tuser (o_m_tuser)
    );

    uss_stats_checker #(
        .CAPACITY(SET_CAP)
    ) stats_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .i_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_m_tdata   (o_m_tdata),
        .i_m_tuser   (o_m_tuser),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // 8 ns clock.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Hard limit on the run time, far beyond the slowest correct run.
    initial begin
        #8_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Offers one command from a falling edge on and returns once it is taken.
    task automatic send_cmd(input logic [1:0] action, input logic [31:0] value);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= action;
        i_s_tdata  <= value;
        do @(posedge i_clk); while (!o_s_tready);
        if (action == uss_pkg::ACT_INSERT) begin
            inserted_vals.insert(inserted_vals.size(), value);
        end else if (action == uss_pkg::ACT_CLEAR) begin
            inserted_vals.delete();
        end
    endtask

    // Value for an insert: often one already stored, else extremes,
    // a narrow band around zero, or anything at all.
    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35 && inserted_vals.size() > 0) begin
            return inserted_vals[$urandom_range(0, inserted_vals.size() - 1)];
        end else if (r < 45) begin
            case ($urandom_range(0, 4))
                0:       return 32'h8000_0000;
                1:       return 32'h7FFF_FFFF;
                2:       return 32'h0000_0000;
                3:       return 32'hFFFF_FFFF;
                default: return 32'h0000_0001;
            endcase
        end else if (r < 60) begin
            return 32'($urandom_range(0, 200)) - 32'd100;
        end
        return $urandom;
    endfunction

    // Result side: random stalls, plus one long hold-off on request.
    initial begin
        int hold_left;
        bit hold_taken;
        hold_left  = 0;
        hold_taken = 1'b0;
        i_m_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off_req && !hold_taken) begin
                hold_left  = HOLD_CYCLES;
                hold_taken = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Command side: reset, directed commands, random bursts, verdict.
    initial begin
        int sent;
        int burst_len;
        int k;
        int r;
        bit first_burst;
        bit hold_done;
        bit drain_done;
        i_rst_n       = 1'b0;
        i_s_tvalid    = 1'b0;
        i_s_tdata     = '0;
        i_s_tuser     = uss_pkg::ACT_INSERT;
        send_idle_pct = 34;
        recv_idle_pct = 67;
        hold_off_req  = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Queries and a clear on the empty set, including the unused code.
        send_cmd(uss_pkg::ACT_QUERY, $urandom);
        send_cmd(ACT_SPARE, $urandom);
        send_cmd(uss_pkg::ACT_CLEAR, $urandom);
        // Extremes; the third insert gives a negative mean that must truncate.
        send_cmd(uss_pkg::ACT_INSERT, 32'h7FFF_FFFF);
        send_cmd(uss_pkg::ACT_INSERT, 32'h8000_0000);
        send_cmd(uss_pkg::ACT_INSERT, 32'hFFFF_FFFF);
        send_cmd(uss_pkg::ACT_INSERT, 32'h7FFF_FFFF);
        send_cmd(uss_pkg::ACT_QUERY, $urandom);
        send_cmd(ACT_SPARE, $urandom);
        send_cmd(uss_pkg::ACT_INSERT, 32'h0000_0000);
        send_cmd(uss_pkg::ACT_INSERT, 32'h0000_0001);
        // Clear a filled set, then clear it again while empty.
        send_cmd(uss_pkg::ACT_CLEAR, $urandom);
        send_cmd(uss_pkg::ACT_CLEAR, $urandom);
        send_cmd(uss_pkg::ACT_INSERT, 32'hFFFF_FFFF);
        send_cmd(uss_pkg::ACT_INSERT, 32'hFFFF_FFFE);
        send_cmd(uss_pkg::ACT_QUERY, $urandom);
        send_cmd(uss_pkg::ACT_CLEAR, $urandom);

        // Random bursts of mostly inserts, each ending with a clear. The first
        // burst is long and never cleared midway, so the set surely fills.
        sent        = 0;
        first_burst = 1'b1;
        hold_done   = 1'b0;
        drain_done  = 1'b0;
        while (sent < RANDOM_ITEMS) begin
            burst_len = first_burst ? 160 : $urandom_range(10, 160);
            for (k = 0; k < burst_len && sent < RANDOM_ITEMS; k++) begin
                if (sent < 350) begin
                    send_idle_pct = 34;
                    recv_idle_pct = 67;
                end else if (sent < 700) begin
                    send_idle_pct = 67;
                    recv_idle_pct = 34;
                end else begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                // Long result stall while commands keep coming.
                if (!hold_done && sent >= 150) begin
                    hold_off_req = 1'b1;
                    hold_done    = 1'b1;
                end
                // Let the block run dry once before going on.
                if (!drain_done && sent >= 520) begin
                    @(negedge i_clk);
                    i_s_tvalid <= 1'b0;
                    while (pending != 0) @(negedge i_clk);
                    drain_done = 1'b1;
                end
                r = $urandom_range(0, 99);
                if (r < 80) begin
                    send_cmd(uss_pkg::ACT_INSERT, pick_value());
                end else if (r < 90) begin
                    send_cmd(uss_pkg::ACT_QUERY, $urandom);
                end else if (r < 94) begin
                    send_cmd(ACT_SPARE, $urandom);
                end else if (r == 94 && !first_burst) begin
                    send_cmd(uss_pkg::ACT_CLEAR, $urandom);
                end else begin
                    send_cmd(uss_pkg::ACT_INSERT, pick_value());
                end
                sent++;
            end
            send_cmd(uss_pkg::ACT_CLEAR, $urandom);
            sent++;
            first_burst = 1'b0;
        end
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;

        // Wait for every result, then a while longer for stray transfers.
        while (pending != 0) @(negedge i_clk);
        repeat (150) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire
